// ----- rtl/core/htcc_pkg.sv -----
package htcc_pkg;

  localparam int unsigned MAX_CLUSTERS_DEF = 32;
  localparam int unsigned MAX_MEMBERS_DEF  = 1024;

  // Member key: detector, view and channel packed together.
  localparam int unsigned KEY_W = 20;

  localparam logic [1:0] VIEW_U = 2'd0;
  localparam logic [1:0] VIEW_V = 2'd1;

  localparam logic [1:0] KIND_HIT    = 2'd0;
  localparam logic [1:0] KIND_REPORT = 2'd1;
  localparam logic [1:0] KIND_NONE   = 2'd2;

  localparam logic CMD_ADD   = 1'b0;
  localparam logic CMD_FLUSH = 1'b1;

  localparam logic [2:0] CFG_TICK_WINDOW    = 3'd0;
  localparam logic [2:0] CFG_CHANNEL_WINDOW = 3'd1;
  localparam logic [2:0] CFG_MIN_HITS       = 3'd2;
  localparam logic [2:0] CFG_CHARGE_CUT     = 3'd3;
  localparam logic [2:0] CFG_TICKS_PER_SMP  = 3'd4;
  localparam logic [2:0] CFG_U_CHANNELS     = 3'd5;
  localparam logic [2:0] CFG_V_CHANNELS     = 3'd6;

  typedef struct packed {
    logic        command;
    logic [7:0]  detector_id;
    logic [1:0]  view_code;
    logic [9:0]  channel_number;
    logic [63:0] start_tick;
    logic [11:0] samples_over;
    logic [23:0] hit_charge;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  result_kind;
    logic [5:0]  cluster_index;
    logic        opened_new;
    logic        hit_dropped;
    logic [10:0] member_count;
    logic [31:0] charge_sum;
    logic        last_result;
  } out_item_t;

  typedef struct packed {
    logic [15:0] tick_window;
    logic [9:0]  channel_window;
    logic [10:0] min_hits;
    logic [31:0] charge_cut;
    logic [7:0]  ticks_per_sample;
    logic [10:0] u_view_channels;
    logic [10:0] v_view_channels;
  } cfg_t;

  typedef struct packed {
    logic [63:0] end_time;
    logic [10:0] size;
    logic [31:0] charge;
  } cluster_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LATCH,
    OP_TSCAN,
    OP_MSCAN,
    OP_URD,
    OP_UPD,
    OP_FSCAN,
    OP_FEND
  } op_e;

  typedef struct packed {
    op_e op;
  } dp_cmd_t;

  typedef struct packed {
    logic ts_done;
    logic ms_done;
    logic fs_done;
    logic out_free;
  } dp_status_t;

  function automatic logic is_neighbour(input logic [KEY_W-1:0] a,
                                        input logic [KEY_W-1:0] b,
                                        input logic [9:0]       cw,
                                        input logic [10:0]      nu,
                                        input logic [10:0]      nv);
    logic [9:0]         ca;
    logic [9:0]         cb;
    logic [9:0]         diff;
    logic [10:0]        nview;
    logic signed [12:0] thr;
    logic               r;
    ca    = a[9:0];
    cb    = b[9:0];
    diff  = (ca > cb) ? (ca - cb) : (cb - ca);
    nview = (a[11:10] == VIEW_U) ? nu : nv;
    thr   = $signed({2'b00, nview}) - $signed({3'b000, cw});
    r     = 1'b0;
    if (a[19:10] == b[19:10]) begin
      if (diff <= cw) begin
        r = 1'b1;
      end else if (a[11:10] == VIEW_U || a[11:10] == VIEW_V) begin
        if ($signed({3'b000, diff}) >= thr) begin
          r = 1'b1;
        end
      end
    end
    return r;
  endfunction

  function automatic logic time_close(input logic [63:0] start,
                                      input logic [63:0] ce,
                                      input logic [15:0] tw);
    logic [63:0] gap;
    gap = start - ce;
    return (start <= ce) || (gap <= {48'd0, tw});
  endfunction

endpackage

// ----- rtl/core/hit_time_channel_clusterer_unit.sv -----
// Hit item: accepted, then a time sweep of the cluster table, a member scan that reads the
// member store one member per cycle, then a read and an update of the matched cluster
// entry; the update waits while the receiver stalls the previous result.
// Flush item: a sweep of the open clusters and a closing result, held while the receiver stalls.
// Reset (rst_ni low, asynchronous) empties both stores and loads the default registers;
// the store contents are not cleared, so no sweep is needed after reset.
module hit_time_channel_clusterer_unit #(
  parameter int unsigned MAX_CLUSTERS = htcc_pkg::MAX_CLUSTERS_DEF,
  parameter int unsigned MAX_MEMBERS  = htcc_pkg::MAX_MEMBERS_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  htcc_pkg::in_item_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output htcc_pkg::out_item_t out_data_o,
  input  logic                cfg_we_i,
  input  logic [2:0]          cfg_index_i,
  input  logic [31:0]         cfg_data_i
);
  import htcc_pkg::*;

  // Configuration registers. The user must write them only while the block is idle; the
  // block itself does not enforce this, and the datapath reads them directly.
  cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.tick_window      <= 16'd100;
      cfg_q.channel_window   <= 10'd2;
      cfg_q.min_hits         <= 11'd1;
      cfg_q.charge_cut       <= 32'd0;
      cfg_q.ticks_per_sample <= 8'd32;
      cfg_q.u_view_channels  <= 11'd800;
      cfg_q.v_view_channels  <= 11'd800;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_TICK_WINDOW:    cfg_q.tick_window      <= cfg_data_i[15:0];
        CFG_CHANNEL_WINDOW: cfg_q.channel_window   <= cfg_data_i[9:0];
        CFG_MIN_HITS:       cfg_q.min_hits         <= cfg_data_i[10:0];
        CFG_CHARGE_CUT:     cfg_q.charge_cut       <= cfg_data_i;
        CFG_TICKS_PER_SMP:  cfg_q.ticks_per_sample <= cfg_data_i[7:0];
        CFG_U_CHANNELS:     cfg_q.u_view_channels  <= cfg_data_i[10:0];
        CFG_V_CHANNELS:     cfg_q.v_view_channels  <= cfg_data_i[10:0];
        default: begin
        end
      endcase
    end
  end

  dp_cmd_t    cmd;
  dp_status_t status;

  // The controller sequences the sweeps; the datapath holds the stores and the
  // result register.
  htcc_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_command_i (in_data_i.command),
    .in_stall_o   (in_stall_o),
    .status_i     (status),
    .cmd_o        (cmd)
  );

  htcc_datapath #(
    .MAX_CLUSTERS (MAX_CLUSTERS),
    .MAX_MEMBERS  (MAX_MEMBERS)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .in_data_i   (in_data_i),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

// ----- rtl/core/htcc_ctrl.sv -----
module htcc_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                in_command_i,
  output logic                in_stall_o,
  input  htcc_pkg::dp_status_t status_i,
  output htcc_pkg::dp_cmd_t    cmd_o
);
  import htcc_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_TSCAN,
    S_MSCAN,
    S_URD,
    S_UPD,
    S_FSCAN,
    S_FEND
  } state_e;

  state_e state_q;
  state_e state_d;

  assign in_stall_o = (state_q != S_IDLE);

  always_comb begin
    state_d   = state_q;
    cmd_o.op  = OP_NONE;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.op = OP_LATCH;
          state_d  = (in_command_i == CMD_FLUSH) ? S_FSCAN : S_TSCAN;
        end
      end
      S_TSCAN: begin
        cmd_o.op = OP_TSCAN;
        if (status_i.ts_done) state_d = S_MSCAN;
      end
      S_MSCAN: begin
        cmd_o.op = OP_MSCAN;
        if (status_i.ms_done) state_d = S_URD;
      end
      S_URD: begin
        cmd_o.op = OP_URD;
        state_d  = S_UPD;
      end
      S_UPD: begin
        if (status_i.out_free) begin
          cmd_o.op = OP_UPD;
          state_d  = S_IDLE;
        end
      end
      S_FSCAN: begin
        if (status_i.out_free) begin
          cmd_o.op = OP_FSCAN;
          if (status_i.fs_done) state_d = S_FEND;
        end
      end
      S_FEND: begin
        if (status_i.out_free) begin
          cmd_o.op = OP_FEND;
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ----- rtl/core/htcc_datapath.sv -----
module htcc_datapath #(
  parameter int unsigned MAX_CLUSTERS = htcc_pkg::MAX_CLUSTERS_DEF,
  parameter int unsigned MAX_MEMBERS  = htcc_pkg::MAX_MEMBERS_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  htcc_pkg::cfg_t       cfg_i,
  input  htcc_pkg::in_item_t   in_data_i,
  input  htcc_pkg::dp_cmd_t    cmd_i,
  output htcc_pkg::dp_status_t status_o,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output htcc_pkg::out_item_t  out_data_o
);
  import htcc_pkg::*;

  localparam int unsigned SW  = (MAX_CLUSTERS > 1) ? $clog2(MAX_CLUSTERS) : 1;
  localparam int unsigned CNW = $clog2(MAX_CLUSTERS + 1);
  localparam int unsigned FW  = $clog2(MAX_MEMBERS + 1);
  localparam int unsigned MAW = $clog2(MAX_MEMBERS);
  localparam int unsigned SCW = (FW > CNW) ? FW : CNW;
  localparam int unsigned MBW = KEY_W + SW;

  // Cluster table and member store.
  cluster_t         cl_mem [MAX_CLUSTERS];
  logic [MBW-1:0]   mb_mem [MAX_MEMBERS];
  cluster_t         cl_rd_q;
  logic [MBW-1:0]   mb_rd_q;

  in_item_t         in_q;
  logic [63:0]      end_q;
  logic [KEY_W-1:0] key_q;
  logic [CNW-1:0]   cnt_q;
  logic [FW-1:0]    fill_q;
  logic [SCW-1:0]   sc_q;
  logic             pv_q;
  logic [SW-1:0]    pi_q;
  logic [MAX_CLUSTERS-1:0] time_ok_q;
  logic             found_q;
  logic [SW-1:0]    tgt_q;
  logic             rep_v_q;
  logic [SW-1:0]    rep_idx_q;
  logic [10:0]      rep_size_q;
  logic [31:0]      rep_charge_q;
  logic             out_valid_q;
  out_item_t        out_q;

  logic             sc_lt_cnt;
  logic             sc_lt_fill;
  logic             out_free;
  logic             cl_re;
  logic [SW-1:0]    cl_ra;
  logic             cl_we;
  logic [SW-1:0]    cl_wa;
  cluster_t         cl_wd;
  logic             mb_re;
  logic             mb_we;
  logic [SW-1:0]    m_slot;
  logic [KEY_W-1:0] m_key;
  logic             m_hit;
  logic             m_take;
  logic             t_ok;
  logic             f_pass;
  logic             drop;
  logic [19:0]      dur;
  logic [64:0]      end_sum;
  logic [63:0]      end_d;
  logic [32:0]      csum;
  out_item_t        hit_out;
  out_item_t        rep_out;
  out_item_t        fend_out;

  assign sc_lt_cnt  = sc_q < SCW'(cnt_q);
  assign sc_lt_fill = sc_q < SCW'(fill_q);
  assign out_free   = !out_valid_q || !out_stall_i;

  assign status_o.ts_done  = !sc_lt_cnt && !pv_q;
  assign status_o.ms_done  = !sc_lt_fill && !pv_q;
  assign status_o.fs_done  = !sc_lt_cnt && !pv_q;
  assign status_o.out_free = out_free;

  // Hit end time, saturating at the top of the 64-bit range.
  assign dur     = 20'(in_data_i.samples_over) * 20'(cfg_i.ticks_per_sample);
  assign end_sum = {1'b0, in_data_i.start_tick} + 65'(dur);
  assign end_d   = end_sum[64] ? '1 : end_sum[63:0];

  assign m_slot = mb_rd_q[SW-1:0];
  assign m_key  = mb_rd_q[MBW-1:SW];
  assign m_hit  = pv_q && time_ok_q[m_slot]
                  && is_neighbour(key_q, m_key, cfg_i.channel_window,
                                  cfg_i.u_view_channels, cfg_i.v_view_channels);
  assign m_take = (cmd_i.op == OP_MSCAN) && m_hit && (!found_q || (m_slot < tgt_q));

  assign t_ok   = time_close(in_q.start_tick, cl_rd_q.end_time, cfg_i.tick_window);
  assign f_pass = pv_q && (cl_rd_q.size >= cfg_i.min_hits)
                  && (cl_rd_q.charge > cfg_i.charge_cut);

  assign drop = (fill_q >= FW'(MAX_MEMBERS))
                || (!found_q && (cnt_q >= CNW'(MAX_CLUSTERS)));

  // Cluster table ports.
  always_comb begin
    cl_re = 1'b0;
    cl_ra = sc_q[SW-1:0];
    priority case (cmd_i.op)
      OP_TSCAN, OP_FSCAN: cl_re = sc_lt_cnt;
      OP_URD: begin
        cl_re = found_q;
        cl_ra = tgt_q;
      end
      default: cl_re = 1'b0;
    endcase
  end

  assign csum  = {1'b0, cl_rd_q.charge} + 33'(in_q.hit_charge);
  assign cl_we = (cmd_i.op == OP_UPD) && !drop;
  assign cl_wa = found_q ? tgt_q : cnt_q[SW-1:0];
  always_comb begin
    if (found_q) begin
      cl_wd.end_time = (end_q > cl_rd_q.end_time) ? end_q : cl_rd_q.end_time;
      cl_wd.size     = cl_rd_q.size + 11'd1;
      cl_wd.charge   = csum[32] ? '1 : csum[31:0];
    end else begin
      cl_wd.end_time = end_q;
      cl_wd.size     = 11'd1;
      cl_wd.charge   = 32'(in_q.hit_charge);
    end
  end

  assign mb_re = (cmd_i.op == OP_MSCAN) && sc_lt_fill;
  assign mb_we = cl_we;

  always_comb begin
    hit_out = '0;
    hit_out.result_kind = KIND_HIT;
    hit_out.last_result = 1'b1;
    if (drop) begin
      hit_out.hit_dropped = 1'b1;
    end else begin
      hit_out.cluster_index = 6'(cl_wa);
      hit_out.opened_new    = !found_q;
      hit_out.member_count  = cl_wd.size;
      hit_out.charge_sum    = cl_wd.charge;
    end
  end

  always_comb begin
    rep_out               = '0;
    rep_out.result_kind   = KIND_REPORT;
    rep_out.cluster_index = 6'(rep_idx_q);
    rep_out.member_count  = rep_size_q;
    rep_out.charge_sum    = rep_charge_q;
    fend_out              = rep_out;
    fend_out.last_result  = 1'b1;
    if (!rep_v_q) begin
      fend_out             = '0;
      fend_out.result_kind = KIND_NONE;
      fend_out.last_result = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cl_we) cl_mem[cl_wa] <= cl_wd;
    if (cl_re) cl_rd_q <= cl_mem[cl_ra];
  end

  always_ff @(posedge clk_i) begin
    if (mb_we) mb_mem[fill_q[MAW-1:0]] <= {key_q, cl_wa};
    if (mb_re) mb_rd_q <= mb_mem[sc_q[MAW-1:0]];
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      fill_q      <= '0;
      sc_q        <= '0;
      pv_q        <= 1'b0;
      time_ok_q   <= '0;
      found_q     <= 1'b0;
      rep_v_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (!out_stall_i) out_valid_q <= 1'b0;
      if (m_take) found_q <= 1'b1;
      unique case (cmd_i.op)
        OP_LATCH: begin
          sc_q      <= '0;
          pv_q      <= 1'b0;
          time_ok_q <= '0;
          found_q   <= 1'b0;
          rep_v_q   <= 1'b0;
        end
        OP_TSCAN, OP_FSCAN: begin
          pv_q <= sc_lt_cnt;
          if (sc_lt_cnt) begin
            sc_q <= sc_q + SCW'(1);
          end else if (!pv_q) begin
            sc_q <= '0;
          end
          if (cmd_i.op == OP_TSCAN && pv_q) time_ok_q[pi_q] <= t_ok;
          if (cmd_i.op == OP_FSCAN && f_pass) begin
            rep_v_q <= 1'b1;
            if (rep_v_q) out_valid_q <= 1'b1;
          end
        end
        OP_MSCAN: begin
          pv_q <= sc_lt_fill;
          if (sc_lt_fill) begin
            sc_q <= sc_q + SCW'(1);
          end else if (!pv_q) begin
            sc_q <= '0;
          end
        end
        OP_UPD: begin
          out_valid_q <= 1'b1;
          if (!drop) begin
            fill_q <= fill_q + FW'(1);
            if (!found_q) cnt_q <= cnt_q + CNW'(1);
          end
        end
        OP_FEND: begin
          out_valid_q <= 1'b1;
          cnt_q       <= '0;
          fill_q      <= '0;
        end
        OP_NONE, OP_URD: begin
        end
        default: begin
        end
      endcase
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (m_take) tgt_q <= m_slot;
    unique case (cmd_i.op)
      OP_LATCH: begin
        in_q  <= in_data_i;
        end_q <= end_d;
        key_q <= {in_data_i.detector_id, in_data_i.view_code, in_data_i.channel_number};
      end
      OP_TSCAN: pi_q <= sc_q[SW-1:0];
      OP_FSCAN: begin
        pi_q <= sc_q[SW-1:0];
        if (f_pass) begin
          rep_idx_q    <= pi_q;
          rep_size_q   <= cl_rd_q.size;
          rep_charge_q <= cl_rd_q.charge;
          if (rep_v_q) out_q <= rep_out;
        end
      end
      OP_UPD:  out_q <= hit_out;
      OP_FEND: out_q <= fend_out;
      default: begin
      end
    endcase
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNW'(MAX_CLUSTERS))
    else $error("open cluster count beyond table depth");
  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= FW'(MAX_MEMBERS))
    else $error("member fill beyond store depth");
  a_tgt_open: assert property (@(posedge clk_i) disable iff (!rst_ni)
    found_q |-> (CNW'(tgt_q) < cnt_q))
    else $error("matched cluster is not an open slot");
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_stall_i) |=> $stable(out_q))
    else $error("pending result overwritten while stalled");
`endif

endmodule

// ----- bench/hit_time_channel_clusterer_unit_tb.sv -----
module hit_time_channel_clusterer_unit_tb;
  import htcc_pkg::*;

  localparam int unsigned NCLUST = 32;
  localparam int unsigned NMEMB  = 1024;
  localparam int unsigned WATCHDOG_LIMIT = 200000;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  in_item_t    in_data;
  logic        out_valid;
  logic        out_stall;
  out_item_t   out_data;
  logic        cfg_we;
  logic [2:0]  cfg_index;
  logic [31:0] cfg_data;

  hit_time_channel_clusterer_unit DUT (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_stall_o(in_stall), .in_data_i(in_data),
    .out_valid_o(out_valid), .out_stall_i(out_stall), .out_data_o(out_data),
    .cfg_we_i(cfg_we), .cfg_index_i(cfg_index), .cfg_data_i(cfg_data)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Shadow copy of the block's registers, kept by write_reg, and of its stores, kept by the predictor.
  logic [15:0] sh_tick_window;
  logic [9:0]  sh_channel_window;
  logic [10:0] sh_min_hits;
  logic [31:0] sh_charge_cut;
  logic [7:0]  sh_ticks_per_sample;
  logic [10:0] sh_u_channels;
  logic [10:0] sh_v_channels;

  logic [63:0] cl_end[NCLUST];
  logic [10:0] cl_size[NCLUST];
  logic [31:0] cl_charge[NCLUST];
  int unsigned cl_open;
  logic [19:0] mem_key[NMEMB];
  int unsigned mem_owner[NMEMB];
  int unsigned mem_fill;

  // Results the block still owes, oldest first.
  out_item_t   pending_results[$];
  int          errors;
  int unsigned idle_cycles;
  bit          hold_receiver;

  function automatic bit channels_adjacent(logic [19:0] a, logic [19:0] b);
    int diff;
    int lim;
    int nview;
    if (a[19:10] != b[19:10]) return 1'b0;
    diff = int'(a[9:0]) - int'(b[9:0]);
    if (diff < 0) diff = -diff;
    lim = int'(sh_channel_window);
    if (diff <= lim) return 1'b1;
    if (a[11:10] == VIEW_U || a[11:10] == VIEW_V) begin
      nview = (a[11:10] == VIEW_U) ? int'(sh_u_channels) : int'(sh_v_channels);
      if (diff >= nview - lim) return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic out_item_t make_result(logic [1:0] kind, int unsigned idx, bit opened,
                                            bit dropped, logic [10:0] cnt, logic [31:0] chg,
                                            bit last);
    out_item_t r;
    r.result_kind   = kind;
    r.cluster_index = idx[5:0];
    r.opened_new    = opened;
    r.hit_dropped   = dropped;
    r.member_count  = cnt;
    r.charge_sum    = chg;
    r.last_result   = last;
    return r;
  endfunction

  // Appends one owed result at the tail of the queue.
  function automatic void queue_result(input out_item_t r);
    pending_results = {pending_results, r};
  endfunction

  // Works out the results caused by one accepted item and updates the shadow state.
  task automatic cluster_predict(input in_item_t it);
    logic [19:0]  key;
    logic [63:0]  dur;
    logic [63:0]  hit_end;
    logic [32:0]  sum;
    int unsigned  target;
    int unsigned  n;
    bit           found;
    out_item_t    r;
    target = 0;
    found  = 1'b0;
    if (it.command == CMD_FLUSH) begin
      n = 0;
      for (int unsigned c = 0; c < cl_open; c++) begin
        if (cl_size[c] >= sh_min_hits && cl_charge[c] > sh_charge_cut) begin
          queue_result(make_result(KIND_REPORT, c, 0, 0, cl_size[c], cl_charge[c], 0));
          n++;
        end
      end
      if (n == 0) begin
        queue_result(make_result(KIND_NONE, 0, 0, 0, 0, 0, 1));
      end else begin
        r = pending_results.pop_back();
        r.last_result = 1'b1;
        queue_result(r);
      end
      cl_open  = 0;
      mem_fill = 0;
    end else begin
      key = {it.detector_id, it.view_code, it.channel_number};
      dur = 64'(it.samples_over) * 64'(sh_ticks_per_sample);
      hit_end = (it.start_tick > ~dur) ? '1 : it.start_tick + dur;
      for (int unsigned c = 0; c < cl_open && !found; c++) begin
        if (!(it.start_tick <= cl_end[c] ||
              it.start_tick - cl_end[c] <= 64'(sh_tick_window))) continue;
        for (int unsigned m = 0; m < mem_fill; m++) begin
          if (mem_owner[m] == c && channels_adjacent(key, mem_key[m])) begin
            found  = 1'b1;
            target = c;
            break;
          end
        end
      end
      if (mem_fill >= NMEMB || (!found && cl_open >= NCLUST)) begin
        queue_result(make_result(KIND_HIT, 0, 0, 1, 0, 0, 1));
      end else begin
        if (!found) begin
          target            = cl_open;
          cl_open++;
          cl_end[target]    = hit_end;
          cl_size[target]   = 1;
          cl_charge[target] = 32'(it.hit_charge);
        end else begin
          if (hit_end > cl_end[target]) cl_end[target] = hit_end;
          cl_size[target]++;
          sum = 33'(cl_charge[target]) + 33'(it.hit_charge);
          cl_charge[target] = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
        end
        mem_key[mem_fill]   = key;
        mem_owner[mem_fill] = target;
        mem_fill++;
        queue_result(make_result(KIND_HIT, target, !found, 0, cl_size[target],
                                 cl_charge[target], 1));
      end
    end
  endtask

  // Receiver: stalls at random, or for a long hold when asked, and checks every item.
  always @(posedge clk) begin
    out_item_t exp_r;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result %h", $time, out_data);
        errors++;
      end else begin
        exp_r = pending_results.pop_front();
        if (out_data.result_kind !== exp_r.result_kind ||
            out_data.cluster_index !== exp_r.cluster_index ||
            out_data.opened_new !== exp_r.opened_new ||
            out_data.hit_dropped !== exp_r.hit_dropped ||
            out_data.member_count !== exp_r.member_count ||
            out_data.charge_sum !== exp_r.charge_sum ||
            out_data.last_result !== exp_r.last_result) begin
          $display("%0t: mismatch expected %h actual %h", $time, exp_r, out_data);
          errors++;
        end
      end
    end
  end

  // Watchdog: counts cycles in which neither side moves an item.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  int unsigned stall_left;
  always @(negedge clk) begin
    if (hold_receiver) begin
      out_stall <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_stall  <= 1'b1;
    end else if ($urandom_range(0, 3) == 0) begin
      stall_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(20, 80) : $urandom_range(0, 3);
      out_stall  <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  function automatic int unsigned random_gap();
    if ($urandom_range(0, 2) != 0) return 0;
    if ($urandom_range(0, 9) == 0) return $urandom_range(20, 100);
    return $urandom_range(1, 3);
  endfunction

  // Offers one item and holds it until the block accepts it. The valid line drops at
  // the falling edge after acceptance, and the next item starts after a random gap.
  task automatic send_item(input in_item_t it);
    int unsigned gap;
    gap = random_gap();
    repeat (gap + 1) @(negedge clk);
    in_valid <= 1'b1;
    in_data  <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    cluster_predict(it);
    @(negedge clk);
    in_valid <= 1'b0;
  endtask

  task automatic wait_drained();
    while (pending_results.size() != 0) @(negedge clk);
    // A flush may still be finishing bookkeeping after its last report.
    repeat (NCLUST + NMEMB + 10) @(negedge clk);
  endtask

  // Register writes happen only with the block idle.
  task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_TICK_WINDOW:    sh_tick_window      = value[15:0];
      CFG_CHANNEL_WINDOW: sh_channel_window   = value[9:0];
      CFG_MIN_HITS:       sh_min_hits         = value[10:0];
      CFG_CHARGE_CUT:     sh_charge_cut       = value;
      CFG_TICKS_PER_SMP:  sh_ticks_per_sample = value[7:0];
      CFG_U_CHANNELS:     sh_u_channels       = value[10:0];
      CFG_V_CHANNELS:     sh_v_channels       = value[10:0];
      default: ;
    endcase
  endtask

  function automatic in_item_t hit_item(logic [7:0] det, logic [1:0] view, logic [9:0] ch,
                                        logic [63:0] st, logic [11:0] smp, logic [23:0] q);
    in_item_t it;
    it.command = CMD_ADD;
    it.detector_id = det;
    it.view_code = view;
    it.channel_number = ch;
    it.start_tick = st;
    it.samples_over = smp;
    it.hit_charge = q;
    return it;
  endfunction

  function automatic in_item_t flush_item();
    in_item_t     it;
    logic [127:0] raw;
    raw = {$urandom, $urandom, $urandom, $urandom};
    it = raw[$bits(in_item_t)-1:0];
    it.command = CMD_FLUSH;
    return it;
  endfunction

  // Random hit drawn near a small number of channels and times so that clusters grow.
  function automatic in_item_t random_hit(logic [63:0] base);
    in_item_t it;
    logic [1:0] view;
    view = ($urandom_range(0, 15) == 0) ? 2'd3 : 2'($urandom_range(0, 2));
    it = hit_item(($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 1)),
                  view,
                  ($urandom_range(0, 3) == 0) ? 10'($urandom) : 10'($urandom_range(0, 12)),
                  ($urandom_range(0, 15) == 0) ? {$urandom, $urandom}
                                               : base + 64'($urandom_range(0, 300)),
                  ($urandom_range(0, 7) == 0) ? 12'($urandom) : 12'($urandom_range(0, 8)),
                  24'($urandom));
    return it;
  endfunction

  typedef struct {
    in_item_t  item;
    bit        typed;
    out_item_t result;
  } stim_row_t;

  stim_row_t directed[$];

  task automatic add_row(input in_item_t it, input bit typed, input out_item_t res);
    stim_row_t row;
    row.item   = it;
    row.typed  = typed;
    row.result = res;
    directed = {directed, row};
  endtask

  initial begin
    stim_row_t   row;
    in_item_t    it;
    logic [63:0] base;
    int unsigned hold;
    errors = 0;
    idle_cycles = 0;
    hold_receiver = 1'b0;
    stall_left = 0;
    in_valid = 1'b0;
    in_data = '0;
    out_stall = 1'b0;
    cfg_we = 1'b0;
    cfg_index = CFG_TICK_WINDOW;
    cfg_data = '0;
    cl_open = 0;
    mem_fill = 0;
    sh_tick_window = 100;
    sh_channel_window = 2;
    sh_min_hits = 1;
    sh_charge_cut = 0;
    sh_ticks_per_sample = 32;
    sh_u_channels = 800;
    sh_v_channels = 800;
    rst_n = 1'b0;
    repeat (3) @(negedge clk);
    rst_n = 1'b1;

    // Directed table: an empty flush, field extremes, joins, wraparound, view three.
    add_row(flush_item(), 1, make_result(KIND_NONE, 0, 0, 0, 0, 0, 1));
    add_row(hit_item(8'hFF, 2'd2, 10'h3FF, '1, 12'hFFF, 24'hFFFFFF), 1,
            make_result(KIND_HIT, 0, 1, 0, 1, 32'hFFFFFF, 1));
    add_row(hit_item(8'h00, 2'd0, 10'd0, 64'd0, 12'd0, 24'd0), 1,
            make_result(KIND_HIT, 1, 1, 0, 1, 0, 1));
    add_row(hit_item(8'h00, 2'd0, 10'd799, 64'd50, 12'd1, 24'd5), 0, '0);
    add_row(hit_item(8'h00, 2'd0, 10'd2, 64'd150, 12'd0, 24'd7), 0, '0);
    add_row(hit_item(8'h00, 2'd1, 10'd798, 64'd10, 12'd0, 24'd1), 0, '0);
    add_row(hit_item(8'h00, 2'd1, 10'd1, 64'd10, 12'd0, 24'd1), 0, '0);
    add_row(hit_item(8'h00, 2'd3, 10'd1023, 64'd10, 12'd0, 24'd1), 0, '0);
    add_row(hit_item(8'h00, 2'd3, 10'd0, 64'd10, 12'd0, 24'd1), 0, '0);
    add_row(hit_item(8'hFF, 2'd2, 10'h3FE, '1, 12'd3, 24'hFFFFFF), 0, '0);
    add_row(hit_item(8'h00, 2'd0, 10'd1, 64'd500, 12'd0, 24'd2), 0, '0);
    add_row(flush_item(), 0, '0);
    foreach (directed[i]) begin
      row = directed[i];
      send_item(row.item);
      if (row.typed) begin
        // The typed result guards the predictor; the receiver checks the block.
        if (pending_results[$] !== row.result) begin
          $display("%0t: mismatch expected %h actual %h", $time, row.result,
                   pending_results[$]);
          errors++;
        end
        wait_drained();
      end
    end
    wait_drained();

    // Long receiver hold while hits keep arriving, so the block backs up.
    hold_receiver = 1'b1;
    fork
      begin
        hold = 0;
        while (hold < 400) begin
          @(negedge clk);
          hold++;
        end
        hold_receiver = 1'b0;
      end
      begin
        for (int k = 0; k < 6; k++) send_item(random_hit(64'd1000));
      end
    join
    send_item(flush_item());
    wait_drained();

    // Random phases over several register settings, extremes among them.
    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        0: begin
          write_reg(CFG_TICK_WINDOW, 32'd0);
          write_reg(CFG_CHANNEL_WINDOW, 32'd0);
          write_reg(CFG_MIN_HITS, 32'd1);
          write_reg(CFG_CHARGE_CUT, 32'd0);
          write_reg(CFG_TICKS_PER_SMP, 32'd1);
          write_reg(CFG_U_CHANNELS, 32'd1);
          write_reg(CFG_V_CHANNELS, 32'd1);
        end
        1: begin
          write_reg(CFG_TICK_WINDOW, 32'd65535);
          write_reg(CFG_CHANNEL_WINDOW, 32'd1023);
          write_reg(CFG_MIN_HITS, 32'd1024);
          write_reg(CFG_CHARGE_CUT, 32'hFFFF_FFFF);
          write_reg(CFG_TICKS_PER_SMP, 32'd255);
          write_reg(CFG_U_CHANNELS, 32'd1024);
          write_reg(CFG_V_CHANNELS, 32'd1024);
        end
        default: begin
          write_reg(CFG_TICK_WINDOW, $urandom_range(0, 400));
          write_reg(CFG_CHANNEL_WINDOW, $urandom_range(0, 4));
          write_reg(CFG_MIN_HITS, $urandom_range(0, 3));
          write_reg(CFG_CHARGE_CUT, ($urandom_range(0, 1) != 0) ? $urandom : 32'd0);
          write_reg(CFG_TICKS_PER_SMP, $urandom_range(1, 255));
          write_reg(CFG_U_CHANNELS, $urandom_range(1, 1024));
          write_reg(CFG_V_CHANNELS, $urandom_range(1, 1024));
        end
      endcase
      base = {$urandom, $urandom} >> 2;
      for (int k = 0; k < 20; k++) begin
        if ($urandom_range(0, 7) == 0) begin
          send_item(flush_item());
        end else begin
          send_item(random_hit(base));
        end
      end
      send_item(flush_item());
      // Sender pauses until the block has delivered every owed result.
      wait_drained();
    end

    // Fill the cluster table past its size to exercise dropped hits.
    write_reg(CFG_TICK_WINDOW, 32'd0);
    write_reg(CFG_CHANNEL_WINDOW, 32'd0);
    write_reg(CFG_MIN_HITS, 32'd1);
    write_reg(CFG_CHARGE_CUT, 32'd0);
    for (int k = 0; k < NCLUST + 3; k++) begin
      it = hit_item(8'(k), 2'd2, 10'(k), 64'(k) * 64'd1000, 12'd0, 24'($urandom));
      send_item(it);
    end
    send_item(flush_item());
    wait_drained();

    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
